// ===== rtl/core/spq_pkg.sv =====
// Shared constants, codes and control types of the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_WIDTH  = 16;

  localparam int MODE_W     = 2;
  localparam int KEY_IN_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 5;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT      = 2'd0,
    MODE_EXTRACT_MIN = 2'd1,
    MODE_EXTRACT_EQ  = 2'd2,
    MODE_EXTRACT_GT  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_NOMATCH = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // Latch the request payload.
    logic search;  // Compare all cells and register the position masks.
    logic commit;  // Shift the cells and load the response register.
  } dp_cmd_t;

endpackage

// ===== rtl/core/spq_req_if.sv =====
// Request channel of the sorted priority queue.
interface spq_req_if;
  logic                           valid;
  logic                           ready;
  logic [spq_pkg::MODE_W-1:0]     mode;
  logic [spq_pkg::KEY_IN_W-1:0]   key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

// ===== rtl/core/spq_rsp_if.sv =====
// Response channel of the sorted priority queue.
interface spq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [spq_pkg::KEY_IN_W-1:0]   removed_key;
  logic [spq_pkg::STATUS_W-1:0]   status;
  logic [spq_pkg::OCC_W-1:0]      occupancy;

  modport source (output valid, output removed_key, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input removed_key, input status, input occupancy,
                  output ready);
endinterface

// ===== rtl/core/spq_ctrl.sv =====
// Controller state machine of the sorted priority queue.
module spq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output spq_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SEARCH = 2'd1,
    S_UPDATE = 2'd2
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o.accept = req_valid_i && in_ready_q;
    cmd_o.search = (state_q == S_SEARCH);
    cmd_o.commit = (state_q == S_UPDATE) && (!out_valid_q || rsp_ready_i);
  end

  assign req_ready_o = in_ready_q;
  assign rsp_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      // A new response replaces the one taken at this edge; otherwise a taken one clears.
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i && in_ready_q) begin
            state_q    <= S_SEARCH;
            in_ready_q <= 1'b0;
          end
        end
        S_SEARCH: begin
          state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          if (!out_valid_q || rsp_ready_i) begin
            in_ready_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  a_search_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |=> state_q == S_UPDATE)
    else $error("search step not followed by update step");

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q && in_ready_q)
    else $error("commit did not present a response and reopen the request side");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_q |-> state_q == S_IDLE && !cmd_o.search && !cmd_o.commit)
    else $error("request side open while an operation is in flight");

endmodule

// ===== rtl/core/spq_dp.sv =====
// Datapath of the sorted priority queue: the sorted cell row, match logic and response register.
module spq_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spq_pkg::dp_cmd_t              cmd_i,
  input  logic [spq_pkg::MODE_W-1:0]    mode_i,
  input  logic [spq_pkg::KEY_IN_W-1:0]  key_i,
  output logic [spq_pkg::KEY_IN_W-1:0]  removed_key_o,
  output logic [spq_pkg::STATUS_W-1:0]  status_o,
  output logic [spq_pkg::OCC_W-1:0]     occupancy_o
);

  logic [spq_pkg::KEY_WIDTH-1:0] entries_q [spq_pkg::CAPACITY];
  logic [spq_pkg::KEY_WIDTH-1:0] entries_d [spq_pkg::CAPACITY];
  logic [spq_pkg::CNT_W-1:0]     count_q;
  logic [spq_pkg::CNT_W-1:0]     count_d;

  spq_pkg::mode_e                op_q;
  logic [spq_pkg::KEY_WIDTH-1:0] key_q;

  logic [spq_pkg::CAPACITY-1:0]  match_d;
  logic [spq_pkg::CAPACITY-1:0]  suffix_d;
  logic [spq_pkg::CAPACITY-1:0]  first_d;
  logic [spq_pkg::CAPACITY-1:0]  suffix_q;
  logic [spq_pkg::CAPACITY-1:0]  first_q;
  spq_pkg::status_e              status_d;
  spq_pkg::status_e              status_q;

  logic [spq_pkg::KEY_WIDTH-1:0] removed_sel;

  logic [spq_pkg::KEY_IN_W-1:0]  removed_q;
  spq_pkg::status_e              rsp_status_q;
  logic [spq_pkg::OCC_W-1:0]     occ_q;

  // Per-cell compare against the latched key; all cells work in parallel.
  always_comb begin
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      logic in_use;
      in_use = (spq_pkg::CNT_W'(i) < count_q);
      case (op_q)
        spq_pkg::MODE_INSERT:
          match_d[i] = (in_use && (entries_q[i] > key_q)) || (spq_pkg::CNT_W'(i) == count_q);
        spq_pkg::MODE_EXTRACT_MIN: match_d[i] = (i == 0) && in_use;
        spq_pkg::MODE_EXTRACT_EQ:  match_d[i] = in_use && (entries_q[i] == key_q);
        spq_pkg::MODE_EXTRACT_GT:  match_d[i] = in_use && (entries_q[i] > key_q);
        default:                   match_d[i] = 1'b0;
      endcase
    end
  end

  // The suffix mask marks every cell at or after the first match.
  always_comb begin
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      suffix_d[i] = 1'b0;
      for (int j = 0; j <= i; j++) begin
        suffix_d[i] = suffix_d[i] | match_d[j];
      end
    end
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      if (i == 0) begin
        first_d[i] = suffix_d[i];
      end else begin
        first_d[i] = suffix_d[i] && !suffix_d[i-1];
      end
    end
  end

  always_comb begin
    if (op_q == spq_pkg::MODE_INSERT) begin
      status_d = (count_q == spq_pkg::CNT_W'(spq_pkg::CAPACITY)) ? spq_pkg::STAT_FULL
                                                                : spq_pkg::STAT_OK;
    end else if (count_q == '0) begin
      status_d = spq_pkg::STAT_EMPTY;
    end else if (|match_d) begin
      status_d = spq_pkg::STAT_OK;
    end else begin
      status_d = spq_pkg::STAT_NOMATCH;
    end
  end

  // Key of the selected cell, picked by a one-hot AND-OR mux.
  always_comb begin
    removed_sel = '0;
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      removed_sel = removed_sel | (first_q[i] ? entries_q[i] : '0);
    end
  end

  // Insert shifts the suffix one cell up; a removal shifts it one cell down.
  always_comb begin
    count_d = count_q;
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      entries_d[i] = entries_q[i];
    end
    if (status_q == spq_pkg::STAT_OK) begin
      if (op_q == spq_pkg::MODE_INSERT) begin
        count_d = count_q + spq_pkg::CNT_W'(1);
        for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
          if (first_q[i]) begin
            entries_d[i] = key_q;
          end else if (suffix_q[i] && (i > 0)) begin
            entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
          end
        end
      end else begin
        count_d = count_q - spq_pkg::CNT_W'(1);
        for (int i = 0; i < spq_pkg::CAPACITY - 1; i++) begin
          if (suffix_q[i]) begin
            entries_d[i] = entries_q[i + 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= spq_pkg::mode_e'(mode_i);
      key_q <= spq_pkg::KEY_WIDTH'(key_i);
    end
    if (cmd_i.search) begin
      suffix_q <= suffix_d;
      first_q  <= first_d;
      status_q <= status_d;
    end
    if (cmd_i.commit) begin
      for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
        entries_q[i] <= entries_d[i];
      end
      if ((status_q == spq_pkg::STAT_OK) && (op_q != spq_pkg::MODE_INSERT)) begin
        removed_q <= spq_pkg::KEY_IN_W'(removed_sel);
      end else begin
        removed_q <= '0;
      end
      rsp_status_q <= status_q;
      occ_q        <= spq_pkg::OCC_W'(count_d);
    end
  end

  assign removed_key_o = removed_q;
  assign status_o      = rsp_status_q;
  assign occupancy_o   = occ_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_single_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> $onehot0(first_q))
    else $error("more than one cell selected");

  a_ok_moves_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && status_q == spq_pkg::STAT_OK |=> count_q != $past(count_q))
    else $error("successful operation left the entry count unchanged");

  a_fail_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && status_q != spq_pkg::STAT_OK |=> count_q == $past(count_q))
    else $error("failed operation changed the entry count");

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller, datapath and channel wiring.
//
// The queue holds up to CAPACITY keys in a row of cells kept in ascending order, equal
// keys in arrival order. Each request names an operation in its mode field: insert the
// key, remove the head, remove the first entry equal to the key, or remove the smallest
// entry strictly greater than the key. Every request gives exactly one response with the
// removed key (zero when nothing was removed), a status of ok, empty, no match or full,
// and the number of entries held afterwards. A request is accepted in the idle state;
// the next cycle compares the key against every cell at once and registers the position
// masks, and the update step then shifts the cells and loads the response register. No
// request is accepted until the one before has finished the controller's three-step
// sequence over the single shared cell row. A response that has not been taken holds
// back only the update step of the following request, which is accepted and searched
// meanwhile. After reset the queue is empty and ready at once.
module sorted_priority_queue (
  input  logic     clk_i,
  input  logic     rst_ni,
  spq_req_if.sink  req_i,
  spq_rsp_if.source rsp_o
);

  spq_pkg::dp_cmd_t cmd;

  // The controller sequences each request and owns both handshakes.
  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // The datapath keeps the sorted cells, the entry count and the response payload.
  spq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mode_i        (req_i.mode),
    .key_i         (req_i.key),
    .removed_key_o (rsp_o.removed_key),
    .status_o      (rsp_o.status),
    .occupancy_o   (rsp_o.occupancy)
  );

endmodule

// ===== verif/spq_response_checker.sv =====
// Checker that watches both channels of the sorted priority queue and compares responses.
module spq_response_checker
  import spq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  logic [MODE_W-1:0]   req_mode_i,
  input  logic [KEY_IN_W-1:0] req_key_i,
  input  logic                rsp_valid_i,
  input  logic                rsp_ready_i,
  input  logic [KEY_IN_W-1:0] rsp_removed_key_i,
  input  logic [STATUS_W-1:0] rsp_status_i,
  input  logic [OCC_W-1:0]    rsp_occupancy_i,
  output int                  outstanding_o,
  output int                  fail_count_o
);

  typedef struct packed {
    logic [KEY_IN_W-1:0] removed_key;
    status_e             status;
    logic [OCC_W-1:0]    occupancy;
  } queue_rsp_t;

  // Shadow copy of the cell row, kept in ascending order.
  logic [KEY_WIDTH-1:0] held_keys [CAPACITY];
  int unsigned          held_count;
  queue_rsp_t           awaited_rsps [$];

  // Applies one request to the shadow row and returns the response it must produce.
  function automatic queue_rsp_t apply_request(mode_e op, logic [KEY_IN_W-1:0] raw_key);
    logic [KEY_WIDTH-1:0] k;
    queue_rsp_t           r;
    int unsigned          pos;
    bit                   hit;
    k             = KEY_WIDTH'(raw_key);
    r.removed_key = '0;
    r.status      = STAT_OK;
    pos           = 0;
    hit           = 1'b0;
    if (op == MODE_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        // A new key goes behind every entry equal to it.
        while (pos < held_count && held_keys[pos] <= k) pos++;
        for (int unsigned i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
        held_keys[pos] = k;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      if (op == MODE_EXTRACT_MIN) begin
        hit = 1'b1;
      end else begin
        for (pos = 0; pos < held_count; pos++) begin
          if ((op == MODE_EXTRACT_EQ && held_keys[pos] == k) ||
              (op == MODE_EXTRACT_GT && held_keys[pos] > k)) begin
            hit = 1'b1;
            break;
          end
        end
      end
      if (hit) begin
        r.removed_key = KEY_IN_W'(held_keys[pos]);
        for (int unsigned i = pos; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
        held_count--;
      end else begin
        r.status = STAT_NOMATCH;
      end
    end
    r.occupancy = OCC_W'(held_count);
    return r;
  endfunction

  function automatic int count_mismatches(queue_rsp_t want, queue_rsp_t seen);
    int errs;
    errs = 0;
    if (seen.removed_key !== want.removed_key) begin
      $display("%0t: removed_key mismatch, expected %h, actual %h",
               $time, want.removed_key, seen.removed_key);
      errs++;
    end
    if (seen.status !== want.status) begin
      $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, seen.status);
      errs++;
    end
    if (seen.occupancy !== want.occupancy) begin
      $display("%0t: occupancy mismatch, expected %0d, actual %0d",
               $time, want.occupancy, seen.occupancy);
      errs++;
    end
    return errs;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    queue_rsp_t want;
    queue_rsp_t seen;
    int         errs;
    if (!rst_ni) begin
      held_count = 0;
      awaited_rsps.delete();
      outstanding_o <= 0;
      fail_count_o  <= 0;
    end else begin
      errs = 0;
      // The response leaving at this edge belongs to an older request, so it is matched first.
      if (rsp_valid_i && rsp_ready_i) begin
        seen.removed_key = rsp_removed_key_i;
        seen.status      = status_e'(rsp_status_i);
        seen.occupancy   = rsp_occupancy_i;
        if (awaited_rsps.size() == 0) begin
          $display("%0t: response with none expected, expected nothing, actual %h/%0d/%0d",
                   $time, seen.removed_key, seen.status, seen.occupancy);
          errs++;
        end else begin
          want = awaited_rsps.pop_front();
          errs += count_mismatches(want, seen);
        end
      end
      if (req_valid_i && req_ready_i) begin
        awaited_rsps.push_back(apply_request(mode_e'(req_mode_i), req_key_i));
      end
      outstanding_o <= awaited_rsps.size();
      fail_count_o  <= fail_count_o + errs;
    end
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top of the sorted priority queue: clock, reset, stimulus and verdict.
module tb;
  import spq_pkg::*;

  // Far above the slowest legal run: every request behind the longest idle gap, every
  // response behind the longest ready stall, the full work of each, plus the long hold.
  localparam int CYCLE_LIMIT = 400000;
  // Length of the long response hold that backs the queue up into its request side.
  localparam int LONG_HOLD   = 300;
  // Cycles allowed after the last response before the verdict.
  localparam int TAIL_CYCLES = 20;

  logic clk;
  logic rst_n;
  int   outstanding;
  int   fail_count;
  int   cycle_count;
  bit   quiet;           // When set, neither side idles.
  int   long_hold_reqs;  // Bumped once per long response hold wanted.

  // A small pool of keys makes duplicates and exact matches common.
  logic [KEY_IN_W-1:0] key_pool [8];

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  sorted_priority_queue u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  spq_response_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .req_valid_i       (req_if.valid),
    .req_ready_i       (req_if.ready),
    .req_mode_i        (req_if.mode),
    .req_key_i         (req_if.key),
    .rsp_valid_i       (rsp_if.valid),
    .rsp_ready_i       (rsp_if.ready),
    .rsp_removed_key_i (rsp_if.removed_key),
    .rsp_status_i      (rsp_if.status),
    .rsp_occupancy_i   (rsp_if.occupancy),
    .outstanding_o     (outstanding),
    .fail_count_o      (fail_count)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Response side. Ready drops in random bursts, and once, on request from the stimulus,
  // for the long hold counted here. During that long hold the queue keeps one response
  // parked and then stops taking requests, which the sender keeps offering.
  initial begin : rsp_sink
    int idle_left;
    int holds_seen;
    idle_left     = 0;
    holds_seen    = 0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_left > 0) begin
        rsp_if.ready <= 1'b0;
        idle_left--;
      end else if (holds_seen != long_hold_reqs) begin
        holds_seen++;
        idle_left    = LONG_HOLD - 1;
        rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        idle_left    = $urandom_range(0, 17);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Offers one request and returns at the edge where it is accepted. Valid stays high
  // across back-to-back requests, so it gets only one assignment per edge. An idle
  // burst before the request drives random noise on mode and key with valid low.
  task automatic send_request(mode_e op, logic [KEY_IN_W-1:0] k);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      req_if.mode  <= MODE_W'($urandom);
      req_if.key   <= KEY_IN_W'($urandom);
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.mode  <= op;
    req_if.key   <= k;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Stops offering requests until the checker holds no expected response. The check
  // comes after an edge, so a request accepted at the calling edge is already counted.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < 8; i++) begin
      key_pool[i] = ($urandom_range(0, 1) != 0) ? KEY_IN_W'($urandom)
                                                : KEY_IN_W'($urandom_range(0, 15));
    end
  endtask

  // Mostly pool keys, now and then an extreme, otherwise anything.
  function automatic logic [KEY_IN_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return key_pool[$urandom_range(0, 7)];
    end else if (r == 6) begin
      if ($urandom_range(0, 1) != 0) return {KEY_IN_W{1'b1}};
      return '0;
    end
    return KEY_IN_W'($urandom);
  endfunction

  // Random requests in segments: fill runs that push past full, drain runs of extracts
  // that push past empty, and mixed runs of every operation.
  task automatic run_random(int n_items);
    int sent;
    int seg;
    int len;
    sent = 0;
    while (sent < n_items) begin
      seg = $urandom_range(0, 3);
      len = (seg < 2) ? $urandom_range(17, 22) : $urandom_range(10, 24);
      if ($urandom_range(0, 3) == 0) refresh_pool();
      for (int i = 0; i < len; i++) begin
        case (seg)
          0: begin
            send_request(MODE_INSERT, pick_key());
          end
          1: begin
            send_request(mode_e'($urandom_range(1, 3)), pick_key());
          end
          default: begin
            send_request(mode_e'($urandom_range(0, 3)), pick_key());
          end
        endcase
      end
      sent += len;
    end
  endtask

  initial begin : stimulus
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.mode    = MODE_INSERT;
    req_if.key     = '0;
    quiet          = 1'b0;
    long_hold_reqs = 0;
    refresh_pool();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Every extract on the empty queue reports empty.
    send_request(MODE_EXTRACT_MIN, 16'h0000);
    send_request(MODE_EXTRACT_EQ,  16'h0000);
    send_request(MODE_EXTRACT_GT,  16'hFFFF);
    // Extremes and duplicates, so equal keys must keep their arrival order.
    send_request(MODE_INSERT, 16'hFFFF);
    send_request(MODE_INSERT, 16'h0000);
    send_request(MODE_INSERT, 16'h8000);
    send_request(MODE_INSERT, 16'h8000);
    send_request(MODE_INSERT, 16'h0000);
    // No match for an exact key, nor above the largest key.
    send_request(MODE_EXTRACT_EQ, 16'h1234);
    send_request(MODE_EXTRACT_GT, 16'hFFFF);
    // Hits of every extract kind, down to the empty queue again.
    send_request(MODE_EXTRACT_EQ,  16'h8000);
    send_request(MODE_EXTRACT_GT,  16'h0000);
    send_request(MODE_EXTRACT_GT,  16'h7FFF);
    send_request(MODE_EXTRACT_MIN, 16'h5555);
    send_request(MODE_EXTRACT_MIN, 16'hAAAA);
    send_request(MODE_EXTRACT_MIN, 16'h0000);

    run_random(600);

    // Long response hold while requests keep coming, then a full drain.
    long_hold_reqs <= long_hold_reqs + 1;
    for (int i = 0; i < 40; i++) begin
      send_request(mode_e'($urandom_range(0, 3)), pick_key());
    end
    wait_drained();

    run_random(600);

    // Last part at full speed on both sides.
    quiet <= 1'b1;
    run_random(480);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
